// ===== hw/rtl/svcp_pkg.sv =====
package svcp_pkg;

  localparam int GRID_HALF_DEF = 8;
  localparam int MAX_SCALE_DEF = 3;

  // Cell indices cover grids up to 32 cells on a side
  localparam int CELL_W = 5;
  localparam int SCALE_W = 2;
  localparam int IDX_W = 12;

  typedef struct packed {
    logic signed [15:0] pos_x;
    logic signed [15:0] pos_y;
    logic signed [15:0] pos_z;
    logic [15:0]        radius_q;
    logic [7:0]         ball_id;
  } in_t;

  typedef struct packed {
    logic [7:0]       out_ball;
    logic [3:0]       cell_x;
    logic [3:0]       cell_y;
    logic [3:0]       z_first;
    logic [3:0]       z_last;
    logic [IDX_W-1:0] first_cell_index;
    logic             scale_clipped;
    logic             last;
  } out_t;

  // Ball context after mapping to cells
  typedef struct packed {
    logic [7:0]         ball;
    logic [CELL_W-1:0]  cx;
    logic [CELL_W-1:0]  cy;
    logic [CELL_W-1:0]  cz;
    logic [SCALE_W-1:0] s;
    logic               clip;
  } ctx_t;

  // One covered column on its way to the z span stage
  typedef struct packed {
    logic [7:0]         ball;
    logic [CELL_W-1:0]  x;
    logic [CELL_W-1:0]  y;
    logic [CELL_W-1:0]  cz;
    logic [SCALE_W-1:0] s;
    logic [4:0]         dxy2;
    logic               clip;
    logic               last;
  } col_t;

  typedef struct packed {
    logic [7:0]         ball;
    logic [CELL_W-1:0]  x;
    logic [CELL_W-1:0]  y;
    logic [CELL_W-1:0]  cz;
    logic [SCALE_W-1:0] t;
    logic               clip;
    logic               last;
  } reach_t;

  function automatic logic [SCALE_W-1:0] abs_diff(logic [CELL_W-1:0] a,
                                                  logic [CELL_W-1:0] b);
    logic [CELL_W-1:0] d;
    d = (a >= b) ? (a - b) : (b - a);
    return d[SCALE_W-1:0];
  endfunction

  function automatic logic [3:0] sq(logic [SCALE_W-1:0] d);
    return 4'(d) * 4'(d);
  endfunction

  // Largest t with t*t <= v, for v up to 9
  function automatic logic [SCALE_W-1:0] isqrt_small(logic [3:0] v);
    logic [SCALE_W-1:0] t;
    if (v >= 4'd9) begin
      t = 2'd3;
    end else if (v >= 4'd4) begin
      t = 2'd2;
    end else if (v >= 4'd1) begin
      t = 2'd1;
    end else begin
      t = 2'd0;
    end
    return t;
  endfunction

  function automatic logic [CELL_W-1:0] span_lo(logic [CELL_W-1:0] c,
                                                logic [SCALE_W-1:0] r);
    return (c >= CELL_W'(r)) ? (c - CELL_W'(r)) : '0;
  endfunction

  function automatic logic [CELL_W-1:0] span_hi(logic [CELL_W-1:0] c,
                                                logic [SCALE_W-1:0] r,
                                                logic [CELL_W-1:0] gmax);
    logic [CELL_W:0] sum;
    sum = (CELL_W+1)'(c) + (CELL_W+1)'(r);
    return (sum > (CELL_W+1)'(gmax)) ? gmax : sum[CELL_W-1:0];
  endfunction

  // Half width in y of the disc slice at column x
  function automatic logic [SCALE_W-1:0] row_reach(logic [CELL_W-1:0] x,
                                                   logic [CELL_W-1:0] cx,
                                                   logic [SCALE_W-1:0] s);
    return isqrt_small(sq(s) - sq(abs_diff(x, cx)));
  endfunction

endpackage

// ===== hw/rtl/svcp_setup.sv =====
module svcp_setup #(
  parameter int GRID_HALF = svcp_pkg::GRID_HALF_DEF,
  parameter int MAX_SCALE = svcp_pkg::MAX_SCALE_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_stall,
  input  svcp_pkg::in_t in_data,
  output logic          ctx_vld,
  output svcp_pkg::ctx_t ctx,
  input  logic          ctx_take
);
  import svcp_pkg::*;

  logic       vld_r;
  ctx_t       ctx_r;
  ctx_t       ctx_nxt;
  logic       load;
  logic [4:0] s_raw;

  function automatic logic [4:0] scale_q15(logic [15:0] v);
    logic [20:0] prod;
    prod = 21'(GRID_HALF) * 21'(v);
    return prod[19:15];
  endfunction

  assign in_stall = vld_r & ~ctx_take;
  assign load = in_valid & ~in_stall;

  always_comb begin
    // flip the sign bit to get pos + 1.0 as unsigned
    ctx_nxt.cx = scale_q15({~in_data.pos_x[15], in_data.pos_x[14:0]});
    ctx_nxt.cy = scale_q15({~in_data.pos_y[15], in_data.pos_y[14:0]});
    ctx_nxt.cz = scale_q15({~in_data.pos_z[15], in_data.pos_z[14:0]});
    s_raw = scale_q15(in_data.radius_q);
    ctx_nxt.clip = (s_raw > 5'(MAX_SCALE));
    ctx_nxt.s = ctx_nxt.clip ? SCALE_W'(MAX_SCALE) : s_raw[SCALE_W-1:0];
    ctx_nxt.ball = in_data.ball_id;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= 1'b0;
    end else if (load) begin
      vld_r <= 1'b1;
    end else if (ctx_take) begin
      vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      ctx_r <= ctx_nxt;
    end
  end

  assign ctx_vld = vld_r;
  assign ctx = ctx_r;

endmodule

// ===== hw/rtl/svcp_scan.sv =====
module svcp_scan #(
  parameter int GRID_HALF = svcp_pkg::GRID_HALF_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           ctx_vld,
  input  svcp_pkg::ctx_t ctx,
  output logic           ctx_take,
  output logic           col_vld,
  output svcp_pkg::col_t col,
  input  logic           col_ready
);
  import svcp_pkg::*;

  localparam logic [CELL_W-1:0] GMAX = CELL_W'(2 * GRID_HALF - 1);

  logic                busy_r;
  ctx_t                ctx_r;
  logic [CELL_W-1:0]   x_r;
  logic [CELL_W-1:0]   y_r;
  logic [CELL_W-1:0]   xhi_r;
  logic                col_vld_r;
  col_t                col_r;
  logic                adv;
  logic                row_end;
  logic                ball_end;
  logic [SCALE_W-1:0]  ry_cur;
  logic [CELL_W-1:0]   yhi_cur;
  logic [CELL_W-1:0]   x_inc;
  logic [CELL_W-1:0]   ylo_next;
  logic [CELL_W-1:0]   xlo_in;
  logic [CELL_W-1:0]   ylo_in;
  logic [SCALE_W-1:0]  dx;
  logic [SCALE_W-1:0]  dy;

  assign ctx_take = ctx_vld & ~busy_r;
  assign adv = busy_r & (~col_vld_r | col_ready);

  always_comb begin
    ry_cur = row_reach(x_r, ctx_r.cx, ctx_r.s);
    yhi_cur = span_hi(ctx_r.cy, ry_cur, GMAX);
    x_inc = x_r + CELL_W'(1);
    ylo_next = span_lo(ctx_r.cy, row_reach(x_inc, ctx_r.cx, ctx_r.s));
    row_end = (y_r == yhi_cur);
    ball_end = row_end & (x_r == xhi_r);
    xlo_in = span_lo(ctx.cx, ctx.s);
    ylo_in = span_lo(ctx.cy, row_reach(xlo_in, ctx.cx, ctx.s));
    dx = abs_diff(x_r, ctx_r.cx);
    dy = abs_diff(y_r, ctx_r.cy);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      col_vld_r <= 1'b0;
    end else begin
      if (ctx_take) begin
        busy_r <= 1'b1;
      end else if (adv && ball_end) begin
        busy_r <= 1'b0;
      end
      if (adv) begin
        col_vld_r <= 1'b1;
      end else if (col_ready) begin
        col_vld_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctx_take) begin
      ctx_r <= ctx;
      x_r <= xlo_in;
      y_r <= ylo_in;
      xhi_r <= span_hi(ctx.cx, ctx.s, GMAX);
    end else if (adv && !ball_end) begin
      // step y along the row, then move to the next row
      if (row_end) begin
        x_r <= x_inc;
        y_r <= ylo_next;
      end else begin
        y_r <= y_r + CELL_W'(1);
      end
    end
    if (adv) begin
      col_r.ball <= ctx_r.ball;
      col_r.x <= x_r;
      col_r.y <= y_r;
      col_r.cz <= ctx_r.cz;
      col_r.s <= ctx_r.s;
      col_r.dxy2 <= 5'(sq(dx)) + 5'(sq(dy));
      col_r.clip <= ctx_r.clip;
      col_r.last <= ball_end;
    end
  end

  assign col_vld = col_vld_r;
  assign col = col_r;

  a_end_drops_busy: assert property (@(posedge clk) disable iff (!rst_n)
    adv && ball_end |=> !busy_r)
    else $error("scan still busy after last column");

  a_x_in_box: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> x_r <= xhi_r)
    else $error("column x ran past box");

endmodule

// ===== hw/rtl/svcp_span.sv =====
module svcp_span #(
  parameter int GRID_HALF = svcp_pkg::GRID_HALF_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           col_vld,
  input  svcp_pkg::col_t col,
  output logic           col_ready,
  output logic           out_valid,
  input  logic           out_stall,
  output svcp_pkg::out_t out_data
);
  import svcp_pkg::*;

  localparam logic [CELL_W-1:0] GMAX = CELL_W'(2 * GRID_HALF - 1);
  localparam logic [IDX_W-1:0] ROW_STEP = IDX_W'(2 * GRID_HALF);
  localparam logic [IDX_W-1:0] PLANE_STEP = IDX_W'(4 * GRID_HALF * GRID_HALF);

  logic              a_vld_r;
  reach_t            a_r;
  logic              b_vld_r;
  out_t              b_r;
  logic              b_ready;
  logic [4:0]        rem;
  logic [CELL_W-1:0] zf;
  logic [CELL_W-1:0] zl;

  assign b_ready = ~b_vld_r | ~out_stall;
  assign col_ready = ~a_vld_r | b_ready;

  always_comb begin
    rem = 5'(sq(col.s)) - col.dxy2;
    zf = span_lo(a_r.cz, a_r.t);
    zl = span_hi(a_r.cz, a_r.t, GMAX);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      a_vld_r <= 1'b0;
      b_vld_r <= 1'b0;
    end else begin
      if (col_ready) begin
        a_vld_r <= col_vld;
      end
      if (b_ready) begin
        b_vld_r <= a_vld_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (col_ready) begin
      a_r.ball <= col.ball;
      a_r.x <= col.x;
      a_r.y <= col.y;
      a_r.cz <= col.cz;
      a_r.t <= isqrt_small(rem[3:0]);
      a_r.clip <= col.clip;
      a_r.last <= col.last;
    end
    if (b_ready) begin
      b_r.out_ball <= a_r.ball;
      b_r.cell_x <= a_r.x[3:0];
      b_r.cell_y <= a_r.y[3:0];
      b_r.z_first <= zf[3:0];
      b_r.z_last <= zl[3:0];
      b_r.first_cell_index <= IDX_W'(a_r.x) + ROW_STEP * IDX_W'(a_r.y)
                              + PLANE_STEP * IDX_W'(zf);
      b_r.scale_clipped <= a_r.clip;
      b_r.last <= a_r.last;
    end
  end

  assign out_valid = b_vld_r;
  assign out_data = b_r;

  a_reach_fits: assert property (@(posedge clk) disable iff (!rst_n)
    col_vld |-> col.dxy2 <= 5'(sq(col.s)))
    else $error("column outside the disc");

  a_last_moves: assert property (@(posedge clk) disable iff (!rst_n)
    a_vld_r && b_ready |=> b_r.last == $past(a_r.last))
    else $error("last flag lost in span stage");

endmodule

// ===== hw/rtl/sphere_voxel_column_painter.sv =====
// Channel  Ports                          Beat
// in       in_valid, in_stall, in_data    one ball: centre, radius, id
// out      out_valid, out_stall, out_data one covered (x,y) column, z span
//
// A ball produces one beat for each covered column, one per cycle while
// out_stall is low; the column scanner takes the next ball only after it
// has sent the last column of the current one, with an idle handover between balls.
// The first beat passes the setup register, the scan state and column
// registers, then the reach and span registers.
// Reset clears all valid bits; no clearing pass.
// Stalls ripple back stage by stage; a held beat stays put and none is dropped.
module sphere_voxel_column_painter #(
  parameter int GRID_HALF = svcp_pkg::GRID_HALF_DEF,
  parameter int MAX_SCALE = svcp_pkg::MAX_SCALE_DEF
) (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_stall,
  input  svcp_pkg::in_t  in_data,
  output logic           out_valid,
  input  logic           out_stall,
  output svcp_pkg::out_t out_data
);
  import svcp_pkg::*;

  logic ctx_vld;
  ctx_t ctx;
  logic ctx_take;
  logic col_vld;
  col_t col;
  logic col_ready;

  svcp_setup #(
    .GRID_HALF(GRID_HALF),
    .MAX_SCALE(MAX_SCALE)
  ) u_setup (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_stall(in_stall),
    .in_data (in_data),
    .ctx_vld (ctx_vld),
    .ctx     (ctx),
    .ctx_take(ctx_take)
  );

  svcp_scan #(
    .GRID_HALF(GRID_HALF)
  ) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctx_vld  (ctx_vld),
    .ctx      (ctx),
    .ctx_take (ctx_take),
    .col_vld  (col_vld),
    .col      (col),
    .col_ready(col_ready)
  );

  svcp_span #(
    .GRID_HALF(GRID_HALF)
  ) u_span (
    .clk      (clk),
    .rst_n    (rst_n),
    .col_vld  (col_vld),
    .col      (col),
    .col_ready(col_ready),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

endmodule
